// ----- design/ssf_pkg.sv -----
// Shared types, constants and helpers for the case-folding substring search.
// Used by every file in the design folder; depends on nothing.

package ssf_pkg;

  // Sizing
  localparam int NEEDLE_MAX    = 16;
  localparam int POSITION_BITS = 16;
  localparam int OFFSET_W      = 16;
  localparam int POS_W         = (POSITION_BITS < OFFSET_W) ? POSITION_BITS : OFFSET_W;
  localparam int LEN_W         = $clog2(NEEDLE_MAX + 1);
  localparam int NIDX_W        = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_CASE_INSENSITIVE = 1'd0;

  // Request kinds
  localparam logic REQ_NEEDLE   = 1'b0;
  localparam logic REQ_HAYSTACK = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_MATCH    = 2'd0;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // ASCII folding: 'A' base, span of the upper-case range, offset to lower case
  localparam logic [7:0] FOLD_LO   = 8'h41;
  localparam logic [7:0] FOLD_SPAN = 8'h19;
  localparam logic [7:0] FOLD_ADD  = 8'h20;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       needle_start;
  } ssf_item_t;

  typedef struct packed {
    logic                valid;
    logic [1:0]          search_status;
    logic [OFFSET_W-1:0] match_offset;
  } ssf_res_t;

  // Fold A-Z to lower case when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] d;
    d = b - FOLD_LO;
    if (en && (d <= FOLD_SPAN)) begin
      return b + FOLD_ADD;
    end
    return b;
  endfunction

endpackage

// ----- design/ssf_if.sv -----
// Stream channel interfaces for the search requests and the search results.
// Depends on ssf_pkg for field widths.

interface ssf_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       needle_start;

  modport source (output valid, output req_type, output data_byte, output needle_start,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input needle_start,
                  output ready);
endinterface

interface ssf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   search_status;
  logic [ssf_pkg::OFFSET_W-1:0] match_offset;

  modport source (output valid, output search_status, output match_offset, input ready);
  modport sink   (input valid, input search_status, input match_offset, output ready);
endinterface

// ----- design/substring_search_case_fold_core.sv -----
// Top level of the streaming first-occurrence substring search with case folding.
// Depends on ssf_pkg, ssf_if, ssf_cfg and ssf_engine.
//
//   channel   | dir | handshake          | beat contents
//   request   | in  | valid/ready        | req_type, data_byte, needle_start
//   response  | out | valid/ready        | search_status, match_offset
//   apb       | in  | psel/penable/pready| case_insensitive at word 0
//
// One beat per cycle sustained while response.ready stays high; a result passes
// through the input register and then the result register.
// The needle compare and partial-match update sit between those two registers.
// rst is synchronous and clears all control state; needle bytes are not cleared.
// A stalled result holds the result register; the input register keeps one more
// beat and then request.ready drops.

module substring_search_case_fold_core (
  input  logic                           clk,
  input  logic                           rst,
  ssf_req_if.sink                        request,
  ssf_rsp_if.source                      response,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic               case_insensitive;
  logic               stage_valid;
  ssf_pkg::ssf_item_t stage_item;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [ssf_pkg::OFFSET_W-1:0] out_offset;
  logic               fire;
  ssf_pkg::ssf_res_t  res;

  ssf_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .case_insensitive (case_insensitive)
  );

  // Consume the staged beat whenever the result register can take a result
  assign fire          = stage_valid && (!out_valid || response.ready);
  assign request.ready = !stage_valid || !out_valid || response.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (request.ready) begin
      stage_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      stage_item.req_type     <= request.req_type;
      stage_item.data_byte    <= request.data_byte;
      stage_item.needle_start <= request.needle_start;
    end
  end

  ssf_engine u_engine (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .item             (stage_item),
    .case_insensitive (case_insensitive),
    .res              (res)
  );

  // Result register: load on fire, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res.valid;
    end else if (response.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_status <= res.search_status;
      out_offset <= res.match_offset;
    end
  end

  assign response.valid         = out_valid;
  assign response.search_status = out_status;
  assign response.match_offset  = out_offset;

endmodule

// ----- design/ssf_cfg.sv -----
// APB-style register block holding the case_insensitive control bit.
// Depends on ssf_pkg for the address map.

module ssf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssf_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           case_insensitive
);

  logic hit_case;

  // Decode the word address, byte lanes ignored
  assign hit_case = (paddr[ssf_pkg::APB_ADDR_W-1:2] == ssf_pkg::REG_CASE_INSENSITIVE);

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      case_insensitive <= 1'b0;
    end else if (psel && penable && pwrite && pready && hit_case) begin
      case_insensitive <= pwdata[0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit_case) begin
      prdata[0] = case_insensitive;
    end
  end

  assign pready = 1'b1;

endmodule

// ----- design/ssf_engine.sv -----
// Needle store, parallel comparators and shift-and search state.
// Updates state on each consumed beat and offers at most one result.
// Depends on ssf_pkg.

module ssf_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ssf_pkg::ssf_item_t item,
  input  logic              case_insensitive,
  output ssf_pkg::ssf_res_t res
);

  localparam int N = ssf_pkg::NEEDLE_MAX;

  logic [7:0]                   needle_store [N];
  logic [ssf_pkg::LEN_W-1:0]    needle_length;
  logic                         needle_overflowed;
  logic [N-1:0]                 partial_match_vector;
  logic [ssf_pkg::POS_W-1:0]    haystack_position;
  logic                         search_finished;

  logic [ssf_pkg::LEN_W-1:0]    needle_length_next;
  logic                         needle_overflowed_next;
  logic [N-1:0]                 partial_match_vector_next;
  logic [ssf_pkg::POS_W-1:0]    haystack_position_next;
  logic                         search_finished_next;

  logic [ssf_pkg::LEN_W-1:0]    len_base;
  logic                         store_we;
  logic [7:0]                   hay_folded;
  logic [N-1:0]                 eq;
  logic [N:0]                   shifted;
  logic [N-1:0]                 nv;
  logic [ssf_pkg::LEN_W-1:0]    len_m1;
  logic                         hit;
  logic                         pos_at_limit;
  logic                         searching;

  // Compare the haystack byte against every live needle byte
  assign hay_folded = ssf_pkg::fold_byte(item.data_byte, case_insensitive);

  always_comb begin
    for (int i = 0; i < N; i++) begin
      eq[i] = (ssf_pkg::LEN_W'(i) < needle_length) &&
              (ssf_pkg::fold_byte(needle_store[i], case_insensitive) == hay_folded);
    end
  end

  assign shifted      = {partial_match_vector, 1'b1};
  assign nv           = shifted[N-1:0] & eq;
  assign len_m1       = needle_length - ssf_pkg::LEN_W'(1);
  assign hit          = nv[len_m1[ssf_pkg::NIDX_W-1:0]];
  assign pos_at_limit = (haystack_position == {ssf_pkg::POS_W{1'b1}});
  assign searching    = !search_finished && (needle_length != '0) && !needle_overflowed;

  // Needle base length after an optional restart
  assign len_base = item.needle_start ? '0 : needle_length;
  assign store_we = fire && (item.req_type == ssf_pkg::REQ_NEEDLE) &&
                    (item.data_byte != 8'd0) && (len_base < ssf_pkg::LEN_W'(N));

  // Next state and result for the consumed beat
  always_comb begin
    needle_length_next        = needle_length;
    needle_overflowed_next    = needle_overflowed;
    partial_match_vector_next = partial_match_vector;
    haystack_position_next    = haystack_position;
    search_finished_next      = search_finished;
    res                       = '0;

    if (item.req_type == ssf_pkg::REQ_NEEDLE) begin
      // Load needle byte, restart search
      needle_length_next        = len_base;
      if (item.needle_start) begin
        needle_overflowed_next = 1'b0;
      end
      partial_match_vector_next = '0;
      haystack_position_next    = '0;
      search_finished_next      = 1'b0;
      if (item.data_byte != 8'd0) begin
        if (len_base < ssf_pkg::LEN_W'(N)) begin
          needle_length_next = len_base + ssf_pkg::LEN_W'(1);
        end else begin
          needle_overflowed_next = 1'b1;
        end
      end
    end else if (item.data_byte == 8'd0) begin
      // Terminator: report no match if still open, then clear
      res.valid                 = !search_finished;
      res.search_status         = ssf_pkg::STATUS_NO_MATCH;
      partial_match_vector_next = '0;
      haystack_position_next    = '0;
      search_finished_next      = 1'b0;
    end else if (searching) begin
      if (hit) begin
        res.valid                 = 1'b1;
        res.search_status         = ssf_pkg::STATUS_MATCH;
        res.match_offset          = ssf_pkg::OFFSET_W'(haystack_position) -
                                    ssf_pkg::OFFSET_W'(len_m1);
        search_finished_next      = 1'b1;
        partial_match_vector_next = '0;
      end else if (pos_at_limit) begin
        res.valid                 = 1'b1;
        res.search_status         = ssf_pkg::STATUS_OVERFLOW;
        search_finished_next      = 1'b1;
        partial_match_vector_next = '0;
      end else begin
        partial_match_vector_next = nv;
        haystack_position_next    = haystack_position + ssf_pkg::POS_W'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_length        <= '0;
      needle_overflowed    <= 1'b0;
      partial_match_vector <= '0;
      haystack_position    <= '0;
      search_finished      <= 1'b0;
    end else if (fire) begin
      needle_length        <= needle_length_next;
      needle_overflowed    <= needle_overflowed_next;
      partial_match_vector <= partial_match_vector_next;
      haystack_position    <= haystack_position_next;
      search_finished      <= search_finished_next;
    end
  end

  // Needle bytes, no reset
  always_ff @(posedge clk) begin
    if (store_we) begin
      needle_store[len_base[ssf_pkg::NIDX_W-1:0]] <= item.data_byte;
    end
  end

endmodule

// ----- design/ssf_checker.sv -----
// Port-level checks for substring_search_case_fold_core, attached by bind.
// Depends on ssf_pkg for status and request codes.

module ssf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           req_type,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [1:0]                     rsp_status,
  input logic [ssf_pkg::OFFSET_W-1:0]   rsp_offset,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [ssf_pkg::APB_ADDR_W-1:0] paddr,
  input logic [ssf_pkg::APB_DATA_W-1:0] pwdata,
  input logic [ssf_pkg::APB_DATA_W-1:0] prdata
);

  // Hold a stalled result beat
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_offset))
    else $error("result beat changed while stalled");

  // A fresh result must come from an accepted haystack beat
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |->
      $past(req_valid && req_ready && (req_type == ssf_pkg::REQ_HAYSTACK), 2))
    else $error("result without a haystack beat two cycles before");

  // Offset is zero unless the status is a match
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ssf_pkg::STATUS_MATCH) |-> rsp_offset == '0)
    else $error("nonzero offset on a non-match result");

  // A write to the control word reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite &&
      (paddr[ssf_pkg::APB_ADDR_W-1:2] == ssf_pkg::REG_CASE_INSENSITIVE)
    |=> (paddr[ssf_pkg::APB_ADDR_W-1:2] != ssf_pkg::REG_CASE_INSENSITIVE) ||
        (prdata[0] == $past(pwdata[0])))
    else $error("case_insensitive read back differs from the last write");

endmodule

bind substring_search_case_fold_core ssf_checker u_ssf_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .req_type   (request.req_type),
  .rsp_valid  (response.valid),
  .rsp_ready  (response.ready),
  .rsp_status (response.search_status),
  .rsp_offset (response.match_offset),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);
